FILE: hw/rtl/complex_arith_unit_macros.svh
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("complex_arith_unit: implication check failed");
`define CAU_ASSERT_NEVER(lbl, a) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
    else $error("complex_arith_unit: forbidden condition seen");
`else
`define CAU_ASSERT_IMP(lbl, a, b)
`define CAU_ASSERT_NEVER(lbl, a)
`endif
`endif

FILE: hw/rtl/cau_pkg.sv
// Shared types, codes and helper functions of the complex arithmetic unit.
package cau_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  localparam int QBITS   = 32;
  localparam int LATENCY = 3 + QBITS + 1;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] qd;
  } cau_lane_t;

  typedef struct packed {
    logic        is_div;
    logic        re_neg;
    logic        im_neg;
    logic        re_ovf;
    logic        im_ovf;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic [1:0]  status;
  } cau_side_t;

  // Returns {saturated, value} for a wide signed value.
  function automatic logic [32:0] sat_wide(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > 65'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -65'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Drops 16 fraction bits, rounding toward zero.
  function automatic logic signed [64:0] trunc16(input logic signed [64:0] v);
    logic [64:0] mag;
    logic [64:0] m;
    logic [64:0] r;
    mag = v[64] ? 65'(-v) : 65'(v);
    m   = mag >> 16;
    r   = v[64] ? 65'(-m) : m;
    return signed'(r);
  endfunction

  // Applies sign and saturation to a quotient magnitude.
  function automatic logic [32:0] sat_div(input logic neg, input logic ovf,
                                          input logic [31:0] q);
    logic [32:0] r;
    if (ovf) begin
      r = {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else if (neg) begin
      if (q > 32'h8000_0000) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'(-q)};
      end
    end else if (q > 32'h7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else begin
      r = {1'b0, q};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/cau_front.sv
// Front pipeline: products, sums and divider preparation (three stages).
module cau_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [1:0]              in_command,
  input  logic signed [31:0]      in_a_real,
  input  logic signed [31:0]      in_a_imag,
  input  logic signed [31:0]      in_b_real,
  input  logic signed [31:0]      in_b_imag,
  output logic                    out_valid,
  output logic [63:0]             out_den,
  output cau_pkg::cau_lane_t      out_lane_re,
  output cau_pkg::cau_lane_t      out_lane_im,
  output cau_pkg::cau_side_t      out_side
);

  // Stage 1: operands and the six products.
  logic               v1_r;
  logic [1:0]         cmd1_r;
  logic signed [31:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [63:0] p_arbr_r, p_aibi_r, p_aibr_r, p_arbi_r, p_brbr_r, p_bibi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    cmd1_r   <= in_command;
    ar1_r    <= in_a_real;
    ai1_r    <= in_a_imag;
    br1_r    <= in_b_real;
    bi1_r    <= in_b_imag;
    p_arbr_r <= in_a_real * in_b_real;
    p_aibi_r <= in_a_imag * in_b_imag;
    p_aibr_r <= in_a_imag * in_b_real;
    p_arbi_r <= in_a_real * in_b_imag;
    p_brbr_r <= in_b_real * in_b_real;
    p_bibi_r <= in_b_imag * in_b_imag;
  end

  // Stage 2: sums per command, divisor norm and zero check.
  logic               v2_r;
  logic [1:0]         cmd2_r;
  logic signed [64:0] re2_r, im2_r;
  logic [63:0]        den2_r;
  logic               dz2_r;
  logic signed [64:0] re2_nxt, im2_nxt;

  always_comb begin
    case (cmd1_r)
      cau_pkg::CMD_ADD: begin
        re2_nxt = 65'(ar1_r) + 65'(br1_r);
        im2_nxt = 65'(ai1_r) + 65'(bi1_r);
      end
      cau_pkg::CMD_SUB: begin
        re2_nxt = 65'(ar1_r) - 65'(br1_r);
        im2_nxt = 65'(ai1_r) - 65'(bi1_r);
      end
      cau_pkg::CMD_MUL: begin
        re2_nxt = 65'(p_arbr_r) - 65'(p_aibi_r);
        im2_nxt = 65'(p_aibr_r) + 65'(p_arbi_r);
      end
      default: begin
        re2_nxt = 65'(p_arbr_r) + 65'(p_aibi_r);
        im2_nxt = 65'(p_aibr_r) - 65'(p_arbi_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    cmd2_r <= cmd1_r;
    re2_r  <= re2_nxt;
    im2_r  <= im2_nxt;
    den2_r <= 64'(p_brbr_r) + 64'(p_bibi_r);
    dz2_r  <= (br1_r == 32'sd0) && (bi1_r == 32'sd0);
  end

  // Stage 3: finish add, subtract and multiply; set up the dividers.
  cau_pkg::cau_side_t side_nxt;
  cau_pkg::cau_lane_t lre_nxt, lim_nxt;
  logic [63:0]        mag_re, mag_im;
  logic [32:0]        s_re, s_im;
  logic               v3_r;
  logic [63:0]        den3_r;
  cau_pkg::cau_lane_t lre3_r, lim3_r;
  cau_pkg::cau_side_t side3_r;

  always_comb begin
    mag_re = re2_r[64] ? 64'(-re2_r) : re2_r[63:0];
    mag_im = im2_r[64] ? 64'(-im2_r) : im2_r[63:0];
    if (cmd2_r == cau_pkg::CMD_MUL) begin
      s_re = cau_pkg::sat_wide(cau_pkg::trunc16(re2_r));
      s_im = cau_pkg::sat_wide(cau_pkg::trunc16(im2_r));
    end else begin
      s_re = cau_pkg::sat_wide(re2_r);
      s_im = cau_pkg::sat_wide(im2_r);
    end
    side_nxt.is_div = (cmd2_r == cau_pkg::CMD_DIV) && !dz2_r;
    side_nxt.re_neg = re2_r[64];
    side_nxt.im_neg = im2_r[64];
    // The quotient reaches 2^32 exactly when the numerator reaches den * 2^16.
    side_nxt.re_ovf = {16'b0, mag_re} >= {den2_r, 16'b0};
    side_nxt.im_ovf = {16'b0, mag_im} >= {den2_r, 16'b0};
    if (cmd2_r == cau_pkg::CMD_DIV) begin
      side_nxt.res_re = 32'd0;
      side_nxt.res_im = 32'd0;
      side_nxt.status = cau_pkg::ST_DIVZERO;
    end else begin
      side_nxt.res_re = s_re[31:0];
      side_nxt.res_im = s_im[31:0];
      side_nxt.status = (s_re[32] || s_im[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
    lre_nxt.rem = {16'b0, mag_re[63:16]};
    lre_nxt.qd  = {mag_re[15:0], 16'b0};
    lim_nxt.rem = {16'b0, mag_im[63:16]};
    lim_nxt.qd  = {mag_im[15:0], 16'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    den3_r  <= den2_r;
    lre3_r  <= lre_nxt;
    lim3_r  <= lim_nxt;
    side3_r <= side_nxt;
  end

  assign out_valid   = v3_r;
  assign out_den     = den3_r;
  assign out_lane_re = lre3_r;
  assign out_lane_im = lim3_r;
  assign out_side    = side3_r;

endmodule

FILE: hw/rtl/cau_div_step.sv
// One registered restoring-division step for the real and imaginary lanes.
module cau_div_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [63:0]        in_den,
  input  cau_pkg::cau_lane_t in_lane_re,
  input  cau_pkg::cau_lane_t in_lane_im,
  input  cau_pkg::cau_side_t in_side,
  output logic               out_valid,
  output logic [63:0]        out_den,
  output cau_pkg::cau_lane_t out_lane_re,
  output cau_pkg::cau_lane_t out_lane_im,
  output cau_pkg::cau_side_t out_side
);

  function automatic cau_pkg::cau_lane_t step(input cau_pkg::cau_lane_t l,
                                              input logic [63:0] den);
    cau_pkg::cau_lane_t r;
    logic [64:0] t;
    logic        ge;
    t     = {l.rem, l.qd[31]};
    ge    = t >= {1'b0, den};
    r.rem = ge ? 64'(t - {1'b0, den}) : t[63:0];
    r.qd  = {l.qd[30:0], ge};
    return r;
  endfunction

  logic               valid_r;
  logic [63:0]        den_r;
  cau_pkg::cau_lane_t lre_r, lim_r;
  cau_pkg::cau_side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    den_r  <= in_den;
    lre_r  <= step(in_lane_re, in_den);
    lim_r  <= step(in_lane_im, in_den);
    side_r <= in_side;
  end

  assign out_valid   = valid_r;
  assign out_den     = den_r;
  assign out_lane_re = lre_r;
  assign out_lane_im = lim_r;
  assign out_side    = side_r;

endmodule

FILE: hw/rtl/complex_arith_unit.sv
// Top level of the pipelined complex arithmetic unit.
//
// A request is taken at a rising edge where start is high and busy is low.
// busy is always low: the pipeline takes one request every cycle.
// Each request carries a command (add, subtract, multiply, divide) and two
// complex Q16.16 operands. Exactly one result comes back per request, in
// request order, on out_result_real, out_result_imag and out_status, with
// out_valid high for one cycle.
// The path is three front stages (products, sums, divider setup), one stage
// per quotient bit for the 32-bit divider, and an output stage.
// All commands take the same path, so results never reorder.
// The receiver cannot stall; results must be captured when out_valid is
// high. Synchronous reset drops every request in flight and clears
// out_valid.
`include "complex_arith_unit_macros.svh"
module complex_arith_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_a_real,
  input  logic signed [31:0] in_a_imag,
  input  logic signed [31:0] in_b_real,
  input  logic signed [31:0] in_b_imag,
  output logic               out_valid,
  output logic signed [31:0] out_result_real,
  output logic signed [31:0] out_result_imag,
  output logic [1:0]         out_status
);

  localparam int N = cau_pkg::QBITS;

  logic               in_acc;
  logic               v_s   [0:N];
  logic [63:0]        den_s [0:N];
  cau_pkg::cau_lane_t lre_s [0:N];
  cau_pkg::cau_lane_t lim_s [0:N];
  cau_pkg::cau_side_t side_s[0:N];

  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  cau_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_acc),
    .in_command  (in_command),
    .in_a_real   (in_a_real),
    .in_a_imag   (in_a_imag),
    .in_b_real   (in_b_real),
    .in_b_imag   (in_b_imag),
    .out_valid   (v_s[0]),
    .out_den     (den_s[0]),
    .out_lane_re (lre_s[0]),
    .out_lane_im (lim_s[0]),
    .out_side    (side_s[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_div
    cau_div_step u_step (
      .clk         (clk),
      .rst_n       (rst_n),
      .in_valid    (v_s[g]),
      .in_den      (den_s[g]),
      .in_lane_re  (lre_s[g]),
      .in_lane_im  (lim_s[g]),
      .in_side     (side_s[g]),
      .out_valid   (v_s[g+1]),
      .out_den     (den_s[g+1]),
      .out_lane_re (lre_s[g+1]),
      .out_lane_im (lim_s[g+1]),
      .out_side    (side_s[g+1])
    );
  end

  // Output stage: sign and saturate the quotients, or pass earlier results.
  logic [32:0]        q_re, q_im;
  logic [31:0]        res_re_nxt, res_im_nxt;
  logic [1:0]         status_nxt;
  logic               valid_r;
  logic [31:0]        res_re_r, res_im_r;
  logic [1:0]         status_r;
  cau_pkg::cau_side_t sd;
  logic               res_is_zero;
  logic               status_known;

  always_comb begin
    sd   = side_s[N];
    q_re = cau_pkg::sat_div(sd.re_neg, sd.re_ovf, lre_s[N].qd);
    q_im = cau_pkg::sat_div(sd.im_neg, sd.im_ovf, lim_s[N].qd);
    if (sd.is_div) begin
      res_re_nxt = q_re[31:0];
      res_im_nxt = q_im[31:0];
      status_nxt = (q_re[32] || q_im[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else begin
      res_re_nxt = sd.res_re;
      res_im_nxt = sd.res_im;
      status_nxt = sd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v_s[N];
    end
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    status_r <= status_nxt;
  end

  assign out_valid       = valid_r;
  assign out_result_real = signed'(res_re_r);
  assign out_result_imag = signed'(res_im_r);
  assign out_status      = status_r;

  assign res_is_zero  = (out_result_real == 32'sd0) && (out_result_imag == 32'sd0);
  assign status_known = out_status inside {cau_pkg::ST_OK, cau_pkg::ST_DIVZERO,
                                           cau_pkg::ST_SAT};

  `CAU_ASSERT_IMP(a_latency, in_acc, ##(cau_pkg::LATENCY) out_valid)
  `CAU_ASSERT_IMP(a_no_orphan, out_valid, $past(in_acc, cau_pkg::LATENCY))
  `CAU_ASSERT_IMP(a_divzero_zero, out_valid && out_status == cau_pkg::ST_DIVZERO, res_is_zero)
  `CAU_ASSERT_NEVER(a_status_code, out_valid && !status_known)

endmodule
